FILE: sv/fwrl_pkg.sv
package fwrl_pkg;

    localparam int CLIENT_SLOTS = 256;
    localparam int TIME_BITS    = 32;
    localparam int COUNT_BITS   = 16;

    localparam int SLOT_BITS    = $clog2(CLIENT_SLOTS);
    localparam int CMP_T_BITS   = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int CMP_C_BITS   = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int PADDR_BITS   = 4;

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_MAX    = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;

    typedef logic [SLOT_BITS-1:0]  t_slot;
    typedef logic [TIME_BITS-1:0]  t_time;
    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic [1:0] {
        K_CLEAR,
        K_PASS,
        K_CHECK
    } t_kind;

    typedef struct packed {
        logic        command;
        logic [7:0]  client_slot;
        logic [31:0] timestamp;
    } t_in;

    typedef struct packed {
        logic        allowed;
        logic [15:0] count_after;
    } t_out;

    typedef struct packed {
        t_kind kind;
        t_slot slot;
        t_time now;
    } t_work;

    typedef struct packed {
        logic        limit_enabled;
        logic [15:0] max_requests;
        logic [31:0] window_length;
    } t_cfg;

    typedef struct packed {
        t_count count;
        t_time  start;
    } t_entry;

endpackage

FILE: sv/fwrl_front.sv
module fwrl_front import fwrl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    input  t_in   i_data,
    output logic  o_stall,
    output logic  o_work_valid,
    output t_work o_work,
    input  logic  i_work_pop
);

    t_work                r_q [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0] r_cnt, n_cnt;
    logic                 push;
    logic                 pop;
    t_work                cls;

    always_comb begin
        cls.slot = t_slot'(32'(i_data.client_slot) % CLIENT_SLOTS);
        cls.now  = t_time'(i_data.timestamp);
        priority if (i_data.command) begin
            cls.kind = K_CLEAR;
        end else if (!i_cfg.limit_enabled) begin
            cls.kind = K_PASS;
        end else begin
            cls.kind = K_CHECK;
        end
    end

    assign o_stall      = (r_cnt == QCNT_BITS'(QUEUE_DEPTH));
    assign push         = i_valid && !o_stall;
    assign o_work_valid = (r_cnt != '0);
    assign pop          = i_work_pop && o_work_valid;
    assign o_work       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? QPTR_BITS'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = pop ? QPTR_BITS'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_cnt    = r_cnt;
        unique case ({push, pop})
            2'b10:   n_cnt = QCNT_BITS'(r_cnt + 1'b1);
            2'b01:   n_cnt = QCNT_BITS'(r_cnt - 1'b1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

endmodule

FILE: sv/fwrl_back.sv
module fwrl_back import fwrl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_work_valid,
    input  t_work i_work,
    output logic  o_work_pop,
    output logic  o_valid,
    output t_out  o_data,
    input  logic  i_stall
);

    t_entry                  r_mem [CLIENT_SLOTS];
    t_entry                  r_rd;
    t_work                   r_work;
    logic                    r_busy, n_busy;
    logic [CLIENT_SLOTS-1:0] r_slot_valid, n_slot_valid;
    logic                    r_out_valid, n_out_valid;
    t_out                    r_out, n_out;
    logic                    fire;
    logic                    hit;
    logic                    expired;
    logic                    under;
    t_time                   diff;
    t_count                  inc;
    logic                    wr_en;
    t_entry                  wr_data;
    logic                    res_allowed;
    t_count                  res_count;

    assign o_work_pop = !r_busy && i_work_valid;
    assign fire       = r_busy && (!r_out_valid || !i_stall);

    assign hit     = r_slot_valid[r_work.slot];
    assign diff    = t_time'(r_work.now - r_rd.start);
    assign expired = CMP_T_BITS'(diff) > CMP_T_BITS'(i_cfg.window_length);
    assign under   = CMP_C_BITS'(r_rd.count) < CMP_C_BITS'(i_cfg.max_requests);
    assign inc     = t_count'(r_rd.count + 1'b1);

    always_comb begin
        wr_en        = 1'b0;
        wr_data      = r_rd;
        res_allowed  = 1'b0;
        res_count    = '0;
        n_slot_valid = r_slot_valid;
        unique case (r_work.kind)
            K_CLEAR: begin
                if (fire) begin
                    n_slot_valid = '0;
                end
            end
            K_PASS: begin
                res_allowed = 1'b1;
            end
            K_CHECK: begin
                priority if (!hit || expired) begin
                    wr_en         = fire;
                    wr_data.count = t_count'(1);
                    wr_data.start = r_work.now;
                    res_allowed   = 1'b1;
                    res_count     = t_count'(1);
                    if (fire) begin
                        n_slot_valid[r_work.slot] = 1'b1;
                    end
                end else if (under) begin
                    wr_en         = fire;
                    wr_data.count = inc;
                    res_allowed   = 1'b1;
                    res_count     = inc;
                end else begin
                    res_count = r_rd.count;
                end
            end
            default: begin
                res_allowed = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (o_work_pop) begin
            n_busy = 1'b1;
        end else if (fire) begin
            n_busy = 1'b0;
        end
        if (fire) begin
            n_out_valid       = 1'b1;
            n_out.allowed     = res_allowed;
            n_out.count_after = 16'(res_count);
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_slot_valid <= '0;
        end else begin
            r_busy       <= n_busy;
            r_out_valid  <= n_out_valid;
            r_slot_valid <= n_slot_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (o_work_pop) begin
            r_work <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_work_pop) begin
            r_rd <= r_mem[i_work.slot];
        end
        if (wr_en) begin
            r_mem[r_work.slot] <= wr_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: sv/fixed_window_rate_limiter_top.sv
// Fixed-window rate limiter, one window per client slot.
// Input channel (i_valid / o_stall / i_data): one transaction is a request
// check or a clear-all command; the transaction is taken on a clock edge
// with i_valid high and o_stall low. Output channel (o_valid / i_stall /
// o_data): one result transaction per input transaction, in order.
// A result passes from the queue through the back end's work and slot-read
// registers to the output register. The back end handles one transaction
// at a time: it reads the slot table (registered read), then updates and
// writes back that slot, and takes no new transaction until it is done.
// A 2-entry queue sits between the input classifier and the back end, so
// input is still taken while a result waits on a stalled output.
// When i_stall is high the output register holds its result; the back end
// then stops, the queue fills and o_stall rises.
// Reset (synchronous, active low) clears the queue, the output valid flag,
// all slot valid bits and the configuration registers (limiting disabled).
// Registers over APB: 0x0 limit_enabled, 0x4 max_requests, 0x8
// window_length; write them only while no transaction is in flight.
module fixed_window_rate_limiter_top import fwrl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  i_valid,
    input  t_in                   i_data,
    output logic                  o_stall,
    output logic                  o_valid,
    output t_out                  o_data,
    input  logic                  i_stall
);

    t_cfg  r_cfg, n_cfg;
    logic  cfg_wr;
    logic  w_valid;
    t_work w_work;
    logic  w_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_ENABLE: n_cfg.limit_enabled = pwdata[0];
                REG_MAX:    n_cfg.max_requests  = pwdata[15:0];
                REG_WINDOW: n_cfg.window_length = pwdata;
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ENABLE: prdata = {31'd0, r_cfg.limit_enabled};
            REG_MAX:    prdata = {16'd0, r_cfg.max_requests};
            REG_WINDOW: prdata = r_cfg.window_length;
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    fwrl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .i_data       (i_data),
        .o_stall      (o_stall),
        .o_work_valid (w_valid),
        .o_work       (w_work),
        .i_work_pop   (w_pop)
    );

    fwrl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_work_valid (w_valid),
        .i_work       (w_work),
        .o_work_pop   (w_pop),
        .o_valid      (o_valid),
        .o_data       (o_data),
        .i_stall      (i_stall)
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_valid)
        else $error("back end popped an empty queue");

    a_pass_only_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.allowed && o_data.count_after == 16'd0) |->
            !r_cfg.limit_enabled)
        else $error("allowed with zero count while limiting enabled");

    a_deny_only_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.allowed && o_data.count_after != 16'd0) |->
            r_cfg.limit_enabled)
        else $error("denied while limiting disabled");

endmodule

FILE: test/fixed_window_rate_limiter_top_tb.sv
module fixed_window_rate_limiter_top_tb;
    import fwrl_pkg::*;

    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   HOLD_CYCLES = 80;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  i_valid = 1'b0;
    t_in                   i_data = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_out                  o_data;
    logic                  i_stall = 1'b0;

    fixed_window_rate_limiter_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    // shadow of the limiter registers and client table
    logic        lim_on;
    logic [15:0] lim_max;
    logic [31:0] lim_window;
    logic        slot_live [256] = '{default: 1'b0};
    logic [15:0] slot_hits [256] = '{default: 16'd0};
    logic [31:0] slot_start [256] = '{default: 32'd0};

    t_in  request_q [$];
    t_out verdict_q [$];

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    logic        long_hold;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic t_out police(t_in req);
        t_out        verdict;
        logic [7:0]  s;
        logic [31:0] age;
        verdict = '0;
        s = req.client_slot;
        age = req.timestamp - slot_start[s];
        if (req.command == CMD_CLEAR) begin
            foreach (slot_live[k]) slot_live[k] = 1'b0;
        end else if (!lim_on) begin
            verdict.allowed = 1'b1;
        end else if (!slot_live[s] || age > lim_window) begin
            slot_live[s] = 1'b1;
            slot_hits[s] = 16'd1;
            slot_start[s] = req.timestamp;
            verdict.allowed = 1'b1;
            verdict.count_after = 16'd1;
        end else if (slot_hits[s] < lim_max) begin
            slot_hits[s] = slot_hits[s] + 16'd1;
            verdict.allowed = 1'b1;
            verdict.count_after = slot_hits[s];
        end else begin
            verdict.count_after = slot_hits[s];
        end
        return verdict;
    endfunction

    task automatic flag(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) verdict_q.push_back(police(i_data));
            if (request_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                i_data  <= request_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (verdict_q.size() == 0) begin
                    flag("unexpected result transaction", 32'(o_data), 32'd0);
                end else begin
                    want = verdict_q.pop_front();
                    if (o_data.allowed !== want.allowed)
                        flag("allowed", 32'(o_data.allowed), 32'(want.allowed));
                    if (o_data.count_after !== want.count_after)
                        flag("count_after", 32'(o_data.count_after),
                             32'(want.count_after));
                end
            end
            i_stall <= long_hold || ($urandom_range(0, 99) < snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE: lim_on     = val[0];
            REG_MAX:    lim_max    = val[15:0];
            REG_WINDOW: lim_window = val;
            default: ;
        endcase
    endtask

    task automatic set_limits(logic en, logic [15:0] max_req, logic [31:0] window);
        apb_write(REG_ENABLE, {31'd0, en});
        apb_write(REG_MAX, {16'd0, max_req});
        apb_write(REG_WINDOW, window);
        @(negedge i_clk);
    endtask

    task automatic set_idling(int unsigned src, int unsigned snk);
        @(negedge i_clk);
        src_idle_pct = src;
        snk_idle_pct = snk;
    endtask

    task automatic add_req(logic cmd, logic [7:0] slot, logic [31:0] ts);
        t_in req;
        req.command = cmd;
        req.client_slot = slot;
        req.timestamp = ts;
        request_q.push_back(req);
    endtask

    task automatic hold_receiver();
        @(negedge i_clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        long_hold = 1'b0;
    endtask

    task automatic settle();
        while (request_q.size() != 0 || i_valid || verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // mostly a few busy clients on a slowly advancing clock, plus noise
    task automatic run_random(int n, int unsigned step_max);
        t_in         req;
        logic [31:0] clock;
        logic [7:0]  hot [4];
        @(negedge i_clk);
        clock = $urandom;
        foreach (hot[k]) hot[k] = 8'($urandom_range(0, 255));
        repeat (n) begin
            req.command = ($urandom_range(0, 99) < 2) ? CMD_CLEAR : CMD_CHECK;
            if ($urandom_range(0, 99) < 80)
                req.client_slot = hot[$urandom_range(0, 3)];
            else
                req.client_slot = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 5) begin
                req.timestamp = $urandom;
            end else begin
                clock = clock + $urandom_range(0, step_max);
                req.timestamp = clock;
            end
            request_q.push_back(req);
        end
    endtask

    initial begin : stimulus
        int unsigned span;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        long_hold = 1'b0;
        src_idle_pct = 21;
        snk_idle_pct = 56;
        lim_on = 1'b0;
        lim_max = '0;
        lim_window = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // limiting off after reset
        add_req(CMD_CHECK, 8'd0, 32'd0);
        add_req(CMD_CHECK, 8'd255, 32'hFFFF_FFFF);
        add_req(CMD_CLEAR, 8'hA5, 32'h5A5A_5A5A);
        settle();

        set_limits(1'b1, 16'd3, 32'd10);
        add_req(CMD_CHECK, 8'd0, 32'd0);
        add_req(CMD_CHECK, 8'd0, 32'd5);
        add_req(CMD_CHECK, 8'd0, 32'd10);
        add_req(CMD_CHECK, 8'd0, 32'd10);
        add_req(CMD_CHECK, 8'd0, 32'd21);
        add_req(CMD_CHECK, 8'd255, 32'hFFFF_FFF8);
        add_req(CMD_CHECK, 8'd255, 32'd2);
        add_req(CMD_CHECK, 8'd255, 32'd3);
        add_req(CMD_CLEAR, 8'h5A, 32'hA5A5_A5A5);
        add_req(CMD_CHECK, 8'd255, 32'd4);
        settle();

        // zero budget still admits the opening request of a window
        set_limits(1'b1, 16'd0, 32'hFFFF_FFFF);
        add_req(CMD_CHECK, 8'd7, 32'd100);
        add_req(CMD_CHECK, 8'd7, 32'd0);
        add_req(CMD_CHECK, 8'd7, 32'd99);
        settle();

        set_limits(1'b1, 16'hFFFF, 32'd0);
        add_req(CMD_CHECK, 8'd1, 32'd50);
        add_req(CMD_CHECK, 8'd1, 32'd50);
        add_req(CMD_CHECK, 8'd1, 32'd51);
        settle();

        set_limits(1'b1, 16'd3, 32'd50);
        run_random(315, 12);
        hold_receiver();
        settle();

        set_limits(1'b1, 16'd0, 32'd20);
        run_random(315, 8);
        settle();

        set_idling(56, 21);
        set_limits(1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        run_random(315, 65535);
        settle();

        set_limits(1'b1, 16'($urandom_range(1, 6)), 32'd0);
        run_random(315, 1);
        hold_receiver();
        settle();

        set_idling(0, 0);
        set_limits(1'b0, 16'd2, 32'd100);
        run_random(315, 100000);
        settle();

        span = $urandom_range(1, 200);
        set_limits(1'b1, 16'($urandom_range(1, 10)), span);
        run_random(315, span / 4 + 1);
        settle();

        repeat (10) @(posedge i_clk);
        if (verdict_q.size() != 0)
            flag("results never returned", 32'(verdict_q.size()), 32'd0);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/fwrl_pkg.sv
sv/fwrl_front.sv
sv/fwrl_back.sv
sv/fixed_window_rate_limiter_top.sv
test/fixed_window_rate_limiter_top_tb.sv
